// File: rtl/textured_triangle_pixel_shader_unit_macros.svh
// Assertion macros for the textured triangle pixel shader unit checker.
`ifndef TEXTURED_TRIANGLE_PIXEL_SHADER_UNIT_MACROS_SVH
`define TEXTURED_TRIANGLE_PIXEL_SHADER_UNIT_MACROS_SVH

// same-cycle implication
`define TTPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// delayed implication
`define TTPS_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

// File: rtl/ttps_pkg.sv
// Shared types and constants of the textured triangle pixel shader.
`default_nettype none
package ttps_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int VTX_W     = WORD_W - FRAC_BITS;
  localparam int OPD_W     = VTX_W + 2;
  localparam int EDGE_W    = 2 * OPD_W;
  localparam int BAR_W     = FRAC_BITS + 2;
  localparam int ACC_W     = BAR_W + WORD_W + 2;
  localparam int DVD_W     = ACC_W + 1;
  localparam int QM_W      = DVD_W - 1;
  localparam int DVS_W     = ACC_W - FRAC_BITS + 1;
  localparam int TSZ_W     = 7;
  localparam int TEX_WORDS = 4096;
  localparam int TEX_AW    = $clog2(TEX_WORDS);
  localparam int TRI_WORDS = 15;
  localparam int IDX_W     = 4;
  localparam int PIX_W     = 6;
  localparam int TADDR_W   = 2 * TSZ_W + 1;

  localparam logic [WORD_W-1:0] DEPTH_FAR  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] DEPTH_NEAR = 32'h8000_0000;
  localparam logic [DVD_W-1:0]  DEPTH_NUM  = DVD_W'(1) << (2 * FRAC_BITS);
  localparam logic [TSZ_W-1:0]  TSZ_RESET  = 7'd64;
  localparam logic [IDX_W-1:0]  TRI_IZ0    = 4'd6;
  localparam logic [IDX_W-1:0]  TRI_NONE   = 4'd15;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TEXEL = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SHADE = 2'd3;

  localparam logic REG_TEX_W = 1'b0;
  localparam logic REG_TEX_H = 1'b1;

  localparam logic [2:0] DIV_B0    = 3'd0;
  localparam logic [2:0] DIV_B1    = 3'd1;
  localparam logic [2:0] DIV_B2    = 3'd2;
  localparam logic [2:0] DIV_DEPTH = 3'd3;
  localparam logic [2:0] DIV_TU    = 3'd4;
  localparam logic [2:0] DIV_TV    = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       clear_step;
    logic       edge_step;
    logic [1:0] edge_idx;
    logic       edge_phase;
    logic       mac_clear;
    logic       mac_step;
    logic [1:0] mac_i;
    logic [1:0] mac_k;
    logic       div_start;
    logic [2:0] div_sel;
    logic       set_covered;
    logic       set_passed;
    logic       tex_read;
    logic       write_back;
  } ttps_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic onscreen;
    logic covered;
    logic div_done;
    logic z_zero;
    logic depth_less;
  } ttps_stat_t;

endpackage
`default_nettype wire

// File: rtl/ttps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ttps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ttps_div.sv
// Radix-2 restoring signed divider, quotient truncated toward zero.
`default_nettype none
module ttps_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [ttps_pkg::DVD_W-1:0] dividend,
  input  wire logic signed [ttps_pkg::DVS_W-1:0] divisor,
  output logic                                done,
  output logic signed [ttps_pkg::DVD_W-1:0]   quotient
);
  import ttps_pkg::*;

  localparam int CNT_W = $clog2(QM_W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [QM_W-1:0]  quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dmag;
  logic [DVD_W-1:0] dvd_abs;
  logic [DVS_W-1:0] dvs_abs;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;

  assign dvd_abs  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
  assign dvs_abs  = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
  assign rem_sh   = {rem, quo[QM_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dmag};
  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dvd_abs[QM_W-1:0];
      rem  <= '0;
      dmag <= dvs_abs;
      neg  <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
    end else if (run) begin
      if (!diff[DVS_W+1]) begin
        rem <= diff[DVS_W-1:0];
        quo <= {quo[QM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVS_W-1:0];
        quo <= {quo[QM_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ttps_datapath.sv
// Shader datapath: setup words, edge functions, divider, accumulators, stores.
`default_nettype none
module ttps_datapath #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ttps_pkg::ttps_cmd_t           cmd,
  output ttps_pkg::ttps_stat_t               status,
  input  wire logic [1:0]                    opcode,
  input  wire logic [ttps_pkg::IDX_W-1:0]    param_index,
  input  wire logic signed [ttps_pkg::WORD_W-1:0] param_value,
  input  wire logic [11:0]                   texel_address,
  input  wire logic [ttps_pkg::WORD_W-1:0]   texel_color,
  input  wire logic [ttps_pkg::PIX_W-1:0]    pixel_x,
  input  wire logic [ttps_pkg::PIX_W-1:0]    pixel_y,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [ttps_pkg::TSZ_W-1:0]    cfg_data,
  output logic                               covered,
  output logic                               depth_passed,
  output logic                               written,
  output logic [ttps_pkg::PIX_W-1:0]         out_x,
  output logic [ttps_pkg::PIX_W-1:0]         out_y,
  output logic [ttps_pkg::WORD_W-1:0]        color_rgba
);
  import ttps_pkg::*;

  localparam int DEPTH_N = SCREEN_W * SCREEN_H;
  localparam int DA_W    = $clog2(DEPTH_N);

  logic [WORD_W-1:0]        tri_w [TRI_WORDS];
  logic [TSZ_W-1:0]         tex_w;
  logic [TSZ_W-1:0]         tex_h;
  logic [DA_W-1:0]          clr_cnt;
  logic [DA_W-1:0]          didx_in;
  logic [DA_W-1:0]          didx;
  logic                     onscreen;

  logic signed [OPD_W-1:0]  vx [3];
  logic signed [OPD_W-1:0]  vy [3];
  logic signed [OPD_W-1:0]  psx, psy, ax, ay, bx, by, opa, opb;
  logic signed [EDGE_W-1:0] mul;
  logic signed [EDGE_W-1:0] eacc;
  logic signed [EDGE_W-1:0] w [4];
  logic                     all_le, all_ge;

  logic signed [BAR_W-1:0]  bar [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic [IDX_W-1:0]         widx;
  logic signed [WORD_W-1:0] wsel;
  logic signed [ACC_W-1:0]  prod;

  logic signed [DVD_W-1:0]  dvd;
  logic signed [DVS_W-1:0]  dvs;
  logic signed [DVS_W-1:0]  zdiv;
  logic                     div_done;
  logic signed [DVD_W-1:0]  quo;
  logic                     fits;
  logic [WORD_W-1:0]        depth_sat;
  logic [WORD_W-1:0]        depth_val;

  logic [TSZ_W-1:0]         tw_eff, th_eff;
  logic [FRAC_BITS+TSZ_W-1:0] cprod;
  logic [TSZ_W-1:0]         col, row;
  logic [TADDR_W-1:0]       tsum;

  logic                     dep_we;
  logic [DA_W-1:0]          dep_waddr;
  logic [WORD_W-1:0]        dep_wdata;
  logic [WORD_W-1:0]        dep_rdata;
  logic [WORD_W-1:0]        tex_rdata;
  logic                     alpha_nz;

  assign onscreen = ({26'd0, pixel_x} < 32'(SCREEN_W)) && ({26'd0, pixel_y} < 32'(SCREEN_H));
  assign didx_in  = DA_W'({26'd0, pixel_x} + {26'd0, pixel_y} * 32'(SCREEN_W));

  // vertices: integer part of setup words
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = OPD_W'($signed(tri_w[2*i][WORD_W-1:FRAC_BITS]));
      vy[i] = OPD_W'($signed(tri_w[2*i+1][WORD_W-1:FRAC_BITS]));
    end
  end

  always_comb begin
    psx = $signed({{(OPD_W-PIX_W){1'b0}}, out_x});
    psy = $signed({{(OPD_W-PIX_W){1'b0}}, out_y});
    ax  = vx[1];
    ay  = vy[1];
    bx  = vx[2];
    by  = vy[2];
    case (cmd.edge_idx)
      2'd0: begin
        ax = vx[1]; ay = vy[1]; bx = vx[2]; by = vy[2];
      end
      2'd1: begin
        ax = vx[2]; ay = vy[2]; bx = vx[0]; by = vy[0];
      end
      2'd2: begin
        ax = vx[0]; ay = vy[0]; bx = vx[1]; by = vy[1];
      end
      default: begin
        psx = vx[0]; psy = vy[0];
        ax = vx[1]; ay = vy[1]; bx = vx[2]; by = vy[2];
      end
    endcase
    if (!cmd.edge_phase) begin
      opa = psx - ax;
      opb = by - ay;
    end else begin
      opa = psy - ay;
      opb = bx - ax;
    end
  end

  assign mul = opa * opb;

  always_comb begin
    all_le = 1'b1;
    all_ge = 1'b1;
    for (int i = 0; i < 3; i++) begin
      all_le = all_le && (w[i][EDGE_W-1] || (w[i] == '0));
      all_ge = all_ge && !w[i][EDGE_W-1];
    end
  end

  assign widx = TRI_IZ0 + {1'b0, cmd.mac_k, 1'b0} + {2'b00, cmd.mac_k} + {2'b00, cmd.mac_i};
  assign wsel = $signed(tri_w[widx]);
  assign prod = bar[cmd.mac_i] * wsel;

  assign zdiv = {acc[0][ACC_W-1], acc[0][ACC_W-1:FRAC_BITS]};

  always_comb begin
    case (cmd.div_sel)
      DIV_B0, DIV_B1, DIV_B2: begin
        dvd = {w[cmd.div_sel[1:0]][EDGE_W-1], w[cmd.div_sel[1:0]], {FRAC_BITS{1'b0}}};
        dvs = {w[3][EDGE_W-1], w[3]};
      end
      DIV_DEPTH: begin
        dvd = $signed(DEPTH_NUM);
        dvs = zdiv;
      end
      DIV_TU: begin
        dvd = {acc[1][ACC_W-1], acc[1][ACC_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
        dvs = zdiv;
      end
      default: begin
        dvd = {acc[2][ACC_W-1], acc[2][ACC_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
        dvs = zdiv;
      end
    endcase
  end

  ttps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign fits      = (&quo[DVD_W-1:WORD_W-1]) || !(|quo[DVD_W-1:WORD_W-1]);
  assign depth_sat = fits ? quo[WORD_W-1:0] : (quo[DVD_W-1] ? DEPTH_NEAR : DEPTH_FAR);

  assign tw_eff = (tex_w == '0) ? TSZ_W'(1) : tex_w;
  assign th_eff = (tex_h == '0) ? TSZ_W'(1) : tex_h;
  assign cprod  = (FRAC_BITS+TSZ_W)'(quo[FRAC_BITS-1:0])
                * (FRAC_BITS+TSZ_W)'((cmd.div_sel == DIV_TU) ? tw_eff - 1'b1 : th_eff - 1'b1);
  assign tsum   = TADDR_W'(col) + TADDR_W'(row) * TADDR_W'(tw_eff);

  assign alpha_nz = tex_rdata[WORD_W-1:WORD_W-8] != '0;

  always_comb begin
    dep_we    = 1'b0;
    dep_waddr = didx;
    dep_wdata = depth_val;
    if (cmd.clear_step) begin
      dep_we    = 1'b1;
      dep_waddr = clr_cnt;
      dep_wdata = DEPTH_FAR;
    end else if (cmd.accept && opcode == OP_CLEAR && onscreen) begin
      dep_we    = 1'b1;
      dep_waddr = didx_in;
      dep_wdata = DEPTH_FAR;
    end else if (cmd.write_back && alpha_nz) begin
      dep_we = 1'b1;
    end
  end

  ttps_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH_N)) u_depth (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .re    (cmd.accept),
    .raddr (didx_in),
    .rdata (dep_rdata)
  );

  ttps_ram #(.WIDTH(WORD_W), .DEPTH(TEX_WORDS)) u_tex (
    .clk   (clk),
    .we    (cmd.accept && opcode == OP_TEXEL),
    .waddr (texel_address[TEX_AW-1:0]),
    .wdata (texel_color),
    .re    (cmd.tex_read),
    .raddr (tsum[TEX_AW-1:0]),
    .rdata (tex_rdata)
  );

  assign status.clear_last = clr_cnt == DA_W'(DEPTH_N - 1);
  assign status.onscreen   = onscreen;
  assign status.covered    = (w[3] != '0) && (all_le || all_ge);
  assign status.div_done   = div_done;
  assign status.z_zero     = zdiv == '0;
  assign status.depth_less = $signed(depth_val) < $signed(dep_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      tex_w        <= TSZ_RESET;
      tex_h        <= TSZ_RESET;
      covered      <= 1'b0;
      depth_passed <= 1'b0;
      written      <= 1'b0;
      for (int i = 0; i < TRI_WORDS; i++) begin
        tri_w[i] <= '0;
      end
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_write) begin
        if (cfg_index == REG_TEX_W) begin
          tex_w <= cfg_data;
        end else begin
          tex_h <= cfg_data;
        end
      end
      if (cmd.accept && opcode == OP_LOAD && param_index != TRI_NONE) begin
        tri_w[param_index] <= param_value;
      end
      if (cmd.accept) begin
        covered      <= 1'b0;
        depth_passed <= 1'b0;
        written      <= 1'b0;
      end
      if (cmd.set_covered) begin
        covered <= 1'b1;
      end
      if (cmd.set_passed) begin
        depth_passed <= 1'b1;
      end
      if (cmd.write_back && alpha_nz) begin
        written <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_x      <= pixel_x;
      out_y      <= pixel_y;
      didx       <= didx_in;
      color_rgba <= '0;
    end
    if (cmd.write_back && alpha_nz) begin
      color_rgba <= tex_rdata;
    end
    if (cmd.edge_step) begin
      if (!cmd.edge_phase) begin
        eacc <= mul;
      end else begin
        w[cmd.edge_idx] <= eacc - mul;
      end
    end
    if (cmd.mac_clear) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
    end else if (cmd.mac_step) begin
      acc[cmd.mac_k] <= acc[cmd.mac_k] + prod;
    end
    if (div_done) begin
      case (cmd.div_sel)
        DIV_B0:    bar[0] <= quo[BAR_W-1:0];
        DIV_B1:    bar[1] <= quo[BAR_W-1:0];
        DIV_B2:    bar[2] <= quo[BAR_W-1:0];
        DIV_DEPTH: depth_val <= depth_sat;
        DIV_TU:    col <= cprod[FRAC_BITS+TSZ_W-1:FRAC_BITS];
        default:   row <= cprod[FRAC_BITS+TSZ_W-1:FRAC_BITS];
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/ttps_ctrl.sv
// Shader controller: sequences clear sweep, edges, divisions and stores.
`default_nettype none
module ttps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           opcode,
  input  wire ttps_pkg::ttps_stat_t status,
  output ttps_pkg::ttps_cmd_t       cmd,
  output logic                      busy,
  output logic                      done
);
  import ttps_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_EDGE  = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_DIVS  = 4'd4;
  localparam logic [3:0] ST_DIVW  = 4'd5;
  localparam logic [3:0] ST_MAC   = 4'd6;
  localparam logic [3:0] ST_ZCHK  = 4'd7;
  localparam logic [3:0] ST_DTEST = 4'd8;
  localparam logic [3:0] ST_TADDR = 4'd9;
  localparam logic [3:0] ST_WB    = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;

  logic [3:0] state;
  logic [2:0] cnt;
  logic [2:0] sel;
  logic [1:0] mac_i;
  logic [1:0] mac_k;

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      sel   <= DIV_B0;
      mac_i <= '0;
      mac_k <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (status.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            cnt <= '0;
            if (opcode == OP_SHADE && status.onscreen) state <= ST_EDGE;
            else state <= ST_EMIT;
          end
        end
        ST_EDGE: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd7) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (status.covered) begin
            sel   <= DIV_B0;
            state <= ST_DIVS;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (status.div_done) begin
            case (sel)
              DIV_B0: begin
                sel <= DIV_B1; state <= ST_DIVS;
              end
              DIV_B1: begin
                sel <= DIV_B2; state <= ST_DIVS;
              end
              DIV_B2: begin
                mac_i <= '0; mac_k <= '0; state <= ST_MAC;
              end
              DIV_DEPTH: state <= ST_DTEST;
              DIV_TU: begin
                sel <= DIV_TV; state <= ST_DIVS;
              end
              default: state <= ST_TADDR;
            endcase
          end
        end
        ST_MAC: begin
          if (mac_i == 2'd2) begin
            mac_i <= '0;
            if (mac_k == 2'd2) state <= ST_ZCHK;
            else mac_k <= mac_k + 1'b1;
          end else begin
            mac_i <= mac_i + 1'b1;
          end
        end
        ST_ZCHK: begin
          if (status.z_zero) begin
            state <= ST_EMIT;
          end else begin
            sel   <= DIV_DEPTH;
            state <= ST_DIVS;
          end
        end
        ST_DTEST: begin
          if (status.depth_less) begin
            sel   <= DIV_TU;
            state <= ST_DIVS;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_TADDR: state <= ST_WB;
        ST_WB:    state <= ST_EMIT;
        ST_EMIT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.div_sel    = sel;
    cmd.mac_i      = mac_i;
    cmd.mac_k      = mac_k;
    cmd.edge_idx   = cnt[2:1];
    cmd.edge_phase = cnt[0];
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE:  cmd.accept = start;
      ST_EDGE:  cmd.edge_step = 1'b1;
      ST_CHECK: begin
        cmd.set_covered = status.covered;
        cmd.mac_clear   = 1'b1;
      end
      ST_DIVS:  cmd.div_start = 1'b1;
      ST_MAC:   cmd.mac_step = 1'b1;
      ST_DTEST: cmd.set_passed = status.depth_less;
      ST_TADDR: cmd.tex_read = 1'b1;
      ST_WB:    cmd.write_back = 1'b1;
      default:  cmd.accept = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/textured_triangle_pixel_shader_unit.sv
// Top level of the textured triangle pixel shader unit.
//
//   channel   handshake             fields
//   command   start / busy          opcode, param_index, param_value,
//                                   texel_address, texel_color, pixel_x, pixel_y
//   config    cfg_write             cfg_index, cfg_data
//   result    done (one cycle)      covered, depth_passed, written, out_x, out_y,
//                                   color_rgba
//
// Load, texel and clear words pass from accept through the emit state to done.
// A shaded word makes up to 6 divisions, in turn, through the shared radix-2
// divider. After reset busy stays high while the depth store is swept to
// farthest. Results cannot be held off by the receiver.
`default_nettype none
module textured_triangle_pixel_shader_unit #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   opcode,
  input  wire logic [3:0]   param_index,
  input  wire logic signed [31:0] param_value,
  input  wire logic [11:0]  texel_address,
  input  wire logic [31:0]  texel_color,
  input  wire logic [5:0]   pixel_x,
  input  wire logic [5:0]   pixel_y,
  input  wire logic         cfg_write,
  input  wire logic         cfg_index,
  input  wire logic [6:0]   cfg_data,
  output logic              done,
  output logic              covered,
  output logic              depth_passed,
  output logic              written,
  output logic [5:0]        out_x,
  output logic [5:0]        out_y,
  output logic [31:0]       color_rgba
);
  import ttps_pkg::*;

  ttps_cmd_t  cmd;
  ttps_stat_t status;

  ttps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ttps_datapath #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (opcode),
    .param_index   (param_index),
    .param_value   (param_value),
    .texel_address (texel_address),
    .texel_color   (texel_color),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .covered       (covered),
    .depth_passed  (depth_passed),
    .written       (written),
    .out_x         (out_x),
    .out_y         (out_y),
    .color_rgba    (color_rgba)
  );

endmodule
`default_nettype wire

// File: rtl/ttps_checker.sv
// Port-level checker for the textured triangle pixel shader unit, with bind.
`default_nettype none
`include "textured_triangle_pixel_shader_unit_macros.svh"
module ttps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  opcode,
  input wire logic        done,
  input wire logic        covered,
  input wire logic        depth_passed,
  input wire logic        written,
  input wire logic [31:0] color_rgba
);
  import ttps_pkg::*;

  `TTPS_ASSERT_DLY2(a_short_word, start && !busy && opcode != OP_SHADE, done, "short word late")
  `TTPS_ASSERT_NXT(a_single_done, done, !done, "done held")
  `TTPS_ASSERT_IMP(a_write_flags, done && written, covered && depth_passed, "write without pass")
  `TTPS_ASSERT_IMP(a_color_zero, done && !written, color_rgba == '0, "color without write")

endmodule

bind textured_triangle_pixel_shader_unit ttps_checker u_ttps_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .done         (done),
  .covered      (covered),
  .depth_passed (depth_passed),
  .written      (written),
  .color_rgba   (color_rgba)
);
`default_nettype wire
